/* hdl/ofbm_pkg.sv */
// shared types and constants of the offset flag map with clear-flag scan
package ofbm_pkg;

  // flag words held in the store
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // length register width and its reset value
  localparam int            LW        = 11;
  localparam logic [LW-1:0] LEN_RESET = 11'd1024;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // configuration register indexes
  localparam int                CFG_IW   = 2;
  localparam logic [CFG_IW-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LEN  = 2'd1;

  // action codes
  localparam logic [2:0] ACT_SET    = 3'd0;
  localparam logic [2:0] ACT_CLR    = 3'd1;
  localparam logic [2:0] ACT_TEST   = 3'd2;
  localparam logic [2:0] ACT_REWIND = 3'd3;
  localparam logic [2:0] ACT_NEXT   = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;   // write a zero word during the reset sweep
    logic accept;     // capture an input transaction, clear the result
    logic load_item;  // point at the word holding the item's flag
    logic load_scan;  // point at the word holding the cursor
    logic mem_rd;     // read the addressed word
    logic mem_wr;     // write back a set or cleared flag
    logic res_test;   // capture the tested flag
    logic res_hit;    // report the clear flag found, move the cursor past it
    logic res_end;    // range exhausted, cursor to the end of the range
    logic rewind;     // cursor back to the base
    logic scan_step;  // move on to the next word of the scan
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [2:0] act;       // action of the current item
    logic       item_in;   // item number lies in range
    logic       cur_in;    // scan cursor lies in range
    logic       hit;       // current word holds a clear flag in range
    logic       last_word; // current word is the last one in range
    logic       clr_last;  // reset sweep at its final word
  } sts_t;

endpackage

/* hdl/ofbm_ctrl.sv */
// controller state machine sequencing each transaction through the datapath
module ofbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  ofbm_pkg::sts_t st,
  output ofbm_pkg::cmd_t cmd
);
  import ofbm_pkg::*;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_DEC  = 6'b000100,
    S_RD   = 6'b001000,
    S_EVAL = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_OUT;
        case (st.act)
          ACT_SET, ACT_CLR, ACT_TEST: begin
            if (st.item_in) begin
              cmd.load_item = 1'b1;
              state_nxt     = S_RD;
            end
          end
          ACT_REWIND: cmd.rewind = 1'b1;
          ACT_NEXT: begin
            if (st.cur_in) begin
              cmd.load_scan = 1'b1;
              state_nxt     = S_RD;
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_OUT;
        case (st.act)
          ACT_SET, ACT_CLR: cmd.mem_wr = 1'b1;
          ACT_TEST:         cmd.res_test = 1'b1;
          ACT_NEXT: begin
            if (st.hit) begin
              cmd.res_hit = 1'b1;
            end else if (st.last_word) begin
              cmd.res_end = 1'b1;
            end else begin
              cmd.scan_step = 1'b1;
              state_nxt     = S_RD;
            end
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> $past(cmd.mem_rd))
    else $error("write-back without a preceding read");

  a_step_reads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |=> cmd.mem_rd)
    else $error("scan step not followed by a word read");

  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> in_tready)
    else $error("block not ready after a result transaction");

endmodule

/* hdl/ofbm_dpath.sv */
// datapath: configuration, flag word store, cursor, scan logic and result registers
module ofbm_dpath #(
  parameter int MAX_BITS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [ofbm_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [2:0]                     item_action,
  input  logic [31:0]                    item_number,
  input  ofbm_pkg::cmd_t                 cmd,
  output ofbm_pkg::sts_t                 st,
  output logic                           flag_is_set,
  output logic                           found,
  output logic [31:0]                    found_number
);
  import ofbm_pkg::*;

  localparam int WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [31:0]       base_r;
  logic [LW-1:0]     len_r;
  logic [31:0]       cursor_r, cursor_nxt;
  logic [2:0]        act_r;
  logic [31:0]       off_r;
  logic [31:0]       curoff_r;
  logic [AW-1:0]     word_r;
  logic [BIT_W-1:0]  bit_r;
  logic              first_r;
  logic [WORD_W-1:0] rdata_r;
  logic              flag_r, found_r;
  logic [31:0]       num_r;

  logic [WORD_W-1:0] mem [WORDS];

  logic [LW-1:0]      ulen, ulen_m1;
  logic [LW-6:0]      lim_word, last_w;
  logic [BIT_W-1:0]   lim_bit;
  logic               full_word;
  logic [WORD_W-1:0]  scan_mask, cand, bit_sel, wdata;
  logic [BIT_W-1:0]   ffs;
  logic [31:0]        pos_num, pos_p1;
  logic               mem_we;

  // length in use, never above the store size
  always_comb begin
    ulen     = (32'(len_r) > 32'(MAX_BITS)) ? LW'(MAX_BITS) : len_r;
    ulen_m1  = ulen - LW'(1);
    lim_word = ulen[LW-1:BIT_W];
    lim_bit  = ulen[BIT_W-1:0];
    last_w   = ulen_m1[LW-1:BIT_W];
  end

  // flags eligible in the current scan word and first clear one among them
  always_comb begin
    full_word = (32'(word_r) < 32'(lim_word));
    for (int i = 0; i < WORD_W; i++) begin
      scan_mask[i] = (full_word || (BIT_W'(i) < lim_bit))
                     && (!first_r || (BIT_W'(i) >= bit_r));
    end
    cand = ~rdata_r & scan_mask;
    ffs  = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) ffs = BIT_W'(i);
    end
  end

  // number of the flag found, and offset from the base of the one past it
  assign pos_num = base_r + 32'({word_r, ffs});
  assign pos_p1  = 32'({word_r, ffs}) + 32'd1;

  // status to the controller
  always_comb begin
    st.act       = act_r;
    st.item_in   = (off_r < 32'(ulen));
    st.cur_in    = (curoff_r < 32'(ulen));
    st.hit       = |cand;
    st.last_word = (32'(word_r) >= 32'(last_w));
    st.clr_last  = (word_r == AW'(WORDS - 1));
  end

  // cursor update
  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.rewind) begin
      cursor_nxt = base_r;
    end else if (cmd.res_hit) begin
      cursor_nxt = base_r + pos_p1;
    end else if (cmd.res_end) begin
      cursor_nxt = base_r + 32'(ulen);
    end
  end

  // configuration registers and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      len_r    <= LEN_RESET;
      cursor_r <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE: base_r <= cfg_data;
          CFG_LEN:  len_r  <= cfg_data[LW-1:0];
          default: ;
        endcase
      end
    end
  end

  // word pointer, cleared during reset so the sweep starts at word zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      bit_r   <= '0;
      first_r <= 1'b0;
    end else if (cmd.clr_step || cmd.scan_step) begin
      word_r  <= word_r + AW'(1);
      first_r <= 1'b0;
    end else if (cmd.load_item) begin
      word_r  <= off_r[BIT_W +: AW];
      bit_r   <= off_r[BIT_W-1:0];
      first_r <= 1'b0;
    end else if (cmd.load_scan) begin
      word_r  <= curoff_r[BIT_W +: AW];
      bit_r   <= curoff_r[BIT_W-1:0];
      first_r <= 1'b1;
    end
  end

  // item capture and offsets from the base
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= item_action;
      off_r    <= item_number - base_r;
      curoff_r <= cursor_r - base_r;
    end
  end

  // write data: zero during the sweep, else the read word with one flag changed
  always_comb begin
    bit_sel = WORD_W'(1) << bit_r;
    if (cmd.clr_step) begin
      wdata = '0;
    end else if (act_r == ACT_SET) begin
      wdata = rdata_r | bit_sel;
    end else begin
      wdata = rdata_r & ~bit_sel;
    end
    mem_we = cmd.clr_step || cmd.mem_wr;
  end

  // flag word store, single port with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) mem[word_r] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[word_r];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flag_r  <= 1'b0;
      found_r <= 1'b0;
      num_r   <= '0;
    end else if (cmd.res_test) begin
      flag_r <= |(rdata_r & bit_sel);
    end else if (cmd.res_hit) begin
      found_r <= 1'b1;
      num_r   <= pos_num;
    end
  end

  assign flag_is_set  = flag_r;
  assign found        = found_r;
  assign found_number = num_r;

endmodule

/* hdl/offset_bitmap_with_unset_scan.sv */
// top level of the offset flag map with clear-flag scan
// A map of up to MAX_BITS flags for the numbers range_base to range_base + range_length - 1,
// kept as 32-flag words in a single-port store with registered read data. After reset a
// clearing pass writes every word to zero, during which no input transaction is taken
// (configuration writes still are). One item is worked on at a time and gives one result.
// Set, clear and test go through decode, a store read and an evaluation; rewind and
// out-of-range items go from decode to the result. A next-unset request reads and evaluates
// one 32-flag word at a time until it finds a clear flag or has evaluated the last word in range.
// A new item is accepted in the cycle after the previous result transaction. Configuration
// is to be written only while idle; the block itself does not enforce it.
module offset_bitmap_with_unset_scan #(
  parameter int MAX_BITS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ofbm_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [31:0]                         cfg_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ofbm_pkg::IN_TDATA_W-1:0]     in_tdata,   // action[2:0], number[34:3]
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ofbm_pkg::OUT_TDATA_W-1:0]    out_tdata   // flag_is_set[0], found[1],
                                                          // found_number[33:2]
);
  import ofbm_pkg::*;

  cmd_t        cmd;
  sts_t        st;
  logic        flag_is_set;
  logic        found;
  logic [31:0] found_number;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  ofbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  ofbm_dpath #(
    .MAX_BITS (MAX_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_action  (in_tdata[2:0]),
    .item_number  (in_tdata[34:3]),
    .cmd          (cmd),
    .st           (st),
    .flag_is_set  (flag_is_set),
    .found        (found),
    .found_number (found_number)
  );

  // result packing, upper bits zero
  assign out_tdata = {(OUT_TDATA_W - 34)'(0), found_number, found, flag_is_set};

endmodule
